FILE: hdl/fpc_pkg.sv
package fpc_pkg;

    // APB address width: five 32-bit registers at byte addresses 0..16
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_START_FLAG       = 3'd0;
    localparam logic [2:0] REG_END_FLAG         = 3'd1;
    localparam logic [2:0] REG_RECORD_LENGTH    = 3'd2;
    localparam logic [2:0] REG_PREAMBLE_LENGTH  = 3'd3;
    localparam logic [2:0] REG_POSTAMBLE_LENGTH = 3'd4;

    // Verdict codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_BAD_START = 2'd1;
    localparam logic [1:0] ERR_BAD_END   = 2'd2;
    localparam logic [1:0] ERR_BAD_CSUM  = 2'd3;

    // Position and length counters
    localparam int POS_W = 15;

    typedef struct packed {
        logic [7:0] start_flag;
        logic [7:0] end_flag;
        logic [6:0] record_length;
        logic [4:0] preamble_length;
        logic [3:0] postamble_length;
    } fpc_cfg_t;

    localparam fpc_cfg_t CFG_RESET = '{
        start_flag:       8'd0,
        end_flag:         8'd0,
        record_length:    7'd17,
        preamble_length:  5'd4,
        postamble_length: 4'd2
    };

    typedef struct packed {
        logic [7:0] byte_value;
        logic       packet_start;
    } fpc_in_t;

    typedef struct packed {
        logic       packet_ok;
        logic [1:0] error_code;
        logic [7:0] record_count;
    } fpc_out_t;

endpackage

FILE: hdl/fpc_apb_regs.sv
module fpc_apb_regs
    import fpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output fpc_cfg_t           cfg
);

    fpc_cfg_t   cfg_reg;
    fpc_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Merge the write beat into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        unique case (reg_index)
            REG_START_FLAG:       cfg_next.start_flag       = pwdata[7:0];
            REG_END_FLAG:         cfg_next.end_flag         = pwdata[7:0];
            REG_RECORD_LENGTH:    cfg_next.record_length    = pwdata[6:0];
            REG_PREAMBLE_LENGTH:  cfg_next.preamble_length  = pwdata[4:0];
            REG_POSTAMBLE_LENGTH: cfg_next.postamble_length = pwdata[3:0];
            default:              cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_START_FLAG:       prdata[7:0] = cfg_reg.start_flag;
            REG_END_FLAG:         prdata[7:0] = cfg_reg.end_flag;
            REG_RECORD_LENGTH:    prdata[6:0] = cfg_reg.record_length;
            REG_PREAMBLE_LENGTH:  prdata[4:0] = cfg_reg.preamble_length;
            REG_POSTAMBLE_LENGTH: prdata[3:0] = cfg_reg.postamble_length;
            default:              prdata = '0;
        endcase
    end

endmodule

FILE: hdl/fpc_frame_core.sv
module fpc_frame_core
    import fpc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fpc_cfg_t cfg,
    input  logic     item_valid,
    input  fpc_in_t  item,
    output logic     result_valid,
    output fpc_out_t result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [POS_W-1:0] body_reg, body_next;
    logic [7:0]       count_reg, count_next;
    logic             mismatch_reg, mismatch_next;
    logic             in_packet_reg, in_packet_next;

    // Lengths clamped to a minimum of two
    logic [4:0] pre_len;
    logic [3:0] post_len;
    assign pre_len  = (cfg.preamble_length < 5'd2) ? 5'd2 : cfg.preamble_length;
    assign post_len = (cfg.postamble_length < 4'd2) ? 4'd2 : cfg.postamble_length;

    // Per-beat update of the frame tracker
    always_comb begin
        logic [POS_W-1:0] pos0;
        logic [7:0]       sum0;
        logic [POS_W-1:0] body0;
        logic [7:0]       count0;
        logic             mis0;
        logic             inp0;
        logic [7:0]       b;
        logic [POS_W:0]   end_pos;
        logic [1:0]       code;

        pos0   = pos_reg;
        sum0   = sum_reg;
        body0  = body_reg;
        count0 = count_reg;
        mis0   = mismatch_reg;
        inp0   = in_packet_reg;
        b      = item.byte_value;
        code   = ERR_OK;

        pos_next       = pos_reg;
        sum_next       = sum_reg;
        body_next      = body_reg;
        count_next     = count_reg;
        mismatch_next  = mismatch_reg;
        in_packet_next = in_packet_reg;
        result_valid   = 1'b0;
        result         = '0;

        end_pos = {1'b0, body0} + {{(POS_W-3){1'b0}}, post_len} - {{POS_W{1'b0}}, 1'b1};

        if (item_valid) begin
            // Restart on a start marker, dropping any open frame
            if (item.packet_start) begin
                pos0   = '0;
                sum0   = '0;
                body0  = '0;
                count0 = '0;
                mis0   = 1'b0;
                inp0   = 1'b1;
                end_pos = {{(POS_W-3){1'b0}}, post_len} - {{POS_W{1'b0}}, 1'b1};
            end
            pos_next       = pos0;
            sum_next       = sum0;
            body_next      = body0;
            count_next     = count0;
            mismatch_next  = mis0;
            in_packet_next = inp0;

            if (inp0) begin
                if (pos0 == '0) begin
                    // Check the start flag
                    if (b != cfg.start_flag) begin
                        result_valid   = 1'b1;
                        code           = ERR_BAD_START;
                        in_packet_next = 1'b0;
                    end else begin
                        sum_next = b;
                        pos_next = POS_W'(1);
                    end
                end else if (pos0 == POS_W'(1)) begin
                    // Latch count and body length
                    count_next = b;
                    body_next  = ({7'd0, b} * {8'd0, cfg.record_length})
                               + {{(POS_W-5){1'b0}}, pre_len};
                    sum_next   = sum0 + b;
                    pos_next   = POS_W'(2);
                end else begin
                    // Accumulate body, then compare the checksum byte
                    if (pos0 < body0) begin
                        sum_next = sum0 + b;
                    end else if (pos0 == body0) begin
                        mismatch_next = (b != sum0);
                    end
                    if ({1'b0, pos0} >= end_pos) begin
                        result_valid   = 1'b1;
                        in_packet_next = 1'b0;
                        priority if (b != cfg.end_flag) begin
                            code = ERR_BAD_END;
                        end else if (mismatch_next) begin
                            code = ERR_BAD_CSUM;
                        end else begin
                            code = ERR_OK;
                        end
                    end else begin
                        pos_next = pos0 + POS_W'(1);
                    end
                end
            end
        end

        result.packet_ok    = (code == ERR_OK);
        result.error_code   = code;
        result.record_count = (code == ERR_BAD_START) ? 8'd0 : count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            body_reg      <= '0;
            count_reg     <= '0;
            mismatch_reg  <= 1'b0;
            in_packet_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            body_reg      <= body_next;
            count_reg     <= count_next;
            mismatch_reg  <= mismatch_next;
            in_packet_reg <= in_packet_next;
        end
    end

endmodule

FILE: hdl/framed_packet_checker.sv
// Framed packet checker.
// Input channel s_*: one packet byte per beat, with packet_start marking byte zero.
// Result channel m_*: one verdict beat per packet (ok, bad start, bad end flag,
// bad checksum) together with the record count taken from byte one (zero on a bad start).
// APB port: start flag, end flag, record length, preamble and postamble lengths;
// write them only while no packet is in flight.
// Throughput: one byte per cycle while m_ready keeps the output register free.
// Each byte is held in an input register and evaluated by the frame tracker once
// the output register can take its verdict; the verdict is registered there and
// drives m_valid. The input register lets one more byte be accepted while a
// verdict waits; while the receiver stalls with a verdict pending, that byte is
// held and s_ready drops until m_ready frees the output register.
// Reset (aresetn low, synchronous) empties both registers, returns the tracker
// to idle and loads the register defaults. Bytes outside a packet are dropped.
module framed_packet_checker
    import fpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpc_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fpc_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    fpc_cfg_t cfg;
    logic     in_valid_reg, in_valid_next;
    fpc_in_t  in_data_reg;
    logic     m_valid_reg, m_valid_next;
    fpc_out_t m_data_reg;
    logic     advance;
    logic     res_valid;
    fpc_out_t res_data;

    fpc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Evaluate the held byte once the output register can take its verdict
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fpc_frame_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item_valid   (advance),
        .item         (in_data_reg),
        .result_valid (res_valid),
        .result       (res_data)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Input and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
